// File: rtl/mcb_pkg.sv
package mcb_pkg;

    localparam int NUM_BANKS   = 10;
    localparam int BANK_IDX_W  = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int WORD_W      = 64;
    localparam int BANK_NUM_W  = 4;
    localparam int UC_EN_W     = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int OUTCOME_W   = 3;

    localparam int ST_VAL_BIT  = 63;
    localparam int ST_OVER_BIT = 62;
    localparam int ST_UC_BIT   = 61;
    localparam int GS_MCIP_BIT = 2;

    localparam logic [BANK_NUM_W-1:0] BANK_COUNT_RST = BANK_NUM_W'(10);
    localparam logic [UC_EN_W-1:0]    UC_EN_RST      = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BANK_COUNT   = 3'd0,
        CFG_CTL_PRESENT  = 3'd1,
        CFG_GLOBAL_CTL   = 3'd2,
        CFG_BANK_UC_EN   = 3'd3,
        CFG_MCE_ENABLE   = 3'd4
    } cfg_index_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_DROP          = 3'd0,
        OC_GLOBAL_OFF    = 3'd1,
        OC_BANK_OFF      = 3'd2,
        OC_RESET         = 3'd3,
        OC_LOGGED_IRQ    = 3'd4,
        OC_LOGGED        = 3'd5,
        OC_OVERFLOW      = 3'd6,
        OC_STATUS_WRITE  = 3'd7
    } outcome_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

// File: rtl/mcb_inject_if.sv
interface mcb_inject_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  command;
    logic [mcb_pkg::BANK_NUM_W-1:0]        bank_index;
    logic [mcb_pkg::WORD_W-1:0]            error_status;
    logic [mcb_pkg::WORD_W-1:0]            global_status_in;
    logic [mcb_pkg::WORD_W-1:0]            error_addr;
    logic [mcb_pkg::WORD_W-1:0]            error_misc;

    modport source (
        output valid, command, bank_index, error_status, global_status_in,
               error_addr, error_misc,
        input  ready
    );

    modport sink (
        input  valid, command, bank_index, error_status, global_status_in,
               error_addr, error_misc,
        output ready
    );
endinterface

// File: rtl/mcb_result_if.sv
interface mcb_result_if;
    logic                                  valid;
    logic                                  ready;
    logic [mcb_pkg::OUTCOME_W-1:0]         outcome;
    logic [mcb_pkg::WORD_W-1:0]            bank_status_now;
    logic [mcb_pkg::WORD_W-1:0]            global_status_now;
    logic                                  raise_interrupt;
    logic                                  request_reset;

    modport source (
        output valid, outcome, bank_status_now, global_status_now,
               raise_interrupt, request_reset,
        input  ready
    );

    modport sink (
        input  valid, outcome, bank_status_now, global_status_now,
               raise_interrupt, request_reset,
        output ready
    );
endinterface

// File: rtl/mcb_ctrl.sv
module mcb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output mcb_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    state_next    = S_EXEC;
                    in_ready_next = 1'b0;
                end
            end
            S_EXEC:
            begin
                state_next     = S_OUT;
                out_valid_next = 1'b1;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b0;
                    in_ready_next  = 1'b1;
                end
            end
            default:
            begin
                state_next     = S_IDLE;
                in_ready_next  = 1'b1;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;
    assign cmd.load  = in_valid && in_ready_reg;
    assign cmd.exec  = (state_reg == S_EXEC);

endmodule

// File: rtl/mcb_datapath.sv
module mcb_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mcb_pkg::ctrl_cmd_t                 cmd,
    input  logic                               cfg_we,
    input  logic [mcb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mcb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               command,
    input  logic [mcb_pkg::BANK_NUM_W-1:0]     bank_index,
    input  logic [mcb_pkg::WORD_W-1:0]         error_status,
    input  logic [mcb_pkg::WORD_W-1:0]         global_status_in,
    input  logic [mcb_pkg::WORD_W-1:0]         error_addr,
    input  logic [mcb_pkg::WORD_W-1:0]         error_misc,
    output logic [mcb_pkg::OUTCOME_W-1:0]      outcome,
    output logic [mcb_pkg::WORD_W-1:0]         bank_status_now,
    output logic [mcb_pkg::WORD_W-1:0]         global_status_now,
    output logic                               raise_interrupt,
    output logic                               request_reset
);

    localparam int NB = mcb_pkg::NUM_BANKS;
    localparam int WW = mcb_pkg::WORD_W;

    logic [mcb_pkg::BANK_NUM_W-1:0] bank_count_reg;
    logic                           ctl_present_reg;
    logic                           global_ctl_reg;
    logic [mcb_pkg::UC_EN_W-1:0]    uc_en_reg;
    logic                           mce_en_reg;

    logic                           cmd_reg;
    logic [mcb_pkg::BANK_NUM_W-1:0] idx_reg;
    logic [WW-1:0]                  st_reg;
    logic [WW-1:0]                  gsi_reg;
    logic [WW-1:0]                  addr_reg;
    logic [WW-1:0]                  misc_reg;

    logic [WW-1:0] status_mem_reg [NB];
    logic [WW-1:0] addr_mem_reg   [NB];
    logic [WW-1:0] misc_mem_reg   [NB];
    logic [WW-1:0] gs_reg;

    logic [mcb_pkg::OUTCOME_W-1:0] outcome_reg;
    logic [WW-1:0]                 bank_now_reg;
    logic [WW-1:0]                 gs_now_reg;
    logic                          irq_reg;
    logic                          rst_req_reg;

    logic [mcb_pkg::BANK_IDX_W-1:0] sel;
    logic                           in_range;
    logic                           uc;
    logic                           bank_uc_on;
    logic [WW-1:0]                  cur;
    logic [WW-1:0]                  over_mask;
    mcb_pkg::outcome_t              oc;
    logic                           wr_status;
    logic                           wr_log;
    logic                           wr_gs;
    logic [WW-1:0]                  status_next;
    logic [WW-1:0]                  gs_next;

    assign sel        = mcb_pkg::BANK_IDX_W'(idx_reg);
    assign in_range   = (idx_reg < bank_count_reg) && (32'(idx_reg) < NB);
    assign uc         = st_reg[mcb_pkg::ST_UC_BIT];
    assign bank_uc_on = (32'(idx_reg) < mcb_pkg::UC_EN_W) && uc_en_reg[idx_reg];
    assign cur        = in_range ? status_mem_reg[sel] : '0;
    assign over_mask  = WW'(1) << mcb_pkg::ST_OVER_BIT;

    always_comb
    begin
        oc          = mcb_pkg::OC_DROP;
        wr_status   = 1'b0;
        wr_log      = 1'b0;
        wr_gs       = 1'b0;
        status_next = cur;
        gs_next     = gs_reg;
        if (cmd_reg)
        begin
            oc      = mcb_pkg::OC_STATUS_WRITE;
            wr_gs   = 1'b1;
            gs_next = gsi_reg;
        end
        else if (!in_range || !st_reg[mcb_pkg::ST_VAL_BIT])
        begin
            oc = mcb_pkg::OC_DROP;
        end
        else if (uc && ctl_present_reg && !global_ctl_reg)
        begin
            oc = mcb_pkg::OC_GLOBAL_OFF;
        end
        else if (uc && !bank_uc_on)
        begin
            oc = mcb_pkg::OC_BANK_OFF;
        end
        else if (uc)
        begin
            if (gs_reg[mcb_pkg::GS_MCIP_BIT] || !mce_en_reg)
            begin
                oc = mcb_pkg::OC_RESET;
            end
            else
            begin
                oc          = mcb_pkg::OC_LOGGED_IRQ;
                wr_status   = 1'b1;
                wr_log      = 1'b1;
                wr_gs       = 1'b1;
                gs_next     = gsi_reg;
                status_next = st_reg | (cur[mcb_pkg::ST_VAL_BIT] ? over_mask : '0);
            end
        end
        else if (!cur[mcb_pkg::ST_VAL_BIT] || !cur[mcb_pkg::ST_UC_BIT])
        begin
            oc          = mcb_pkg::OC_LOGGED;
            wr_status   = 1'b1;
            wr_log      = 1'b1;
            status_next = st_reg | (cur[mcb_pkg::ST_VAL_BIT] ? over_mask : '0);
        end
        else
        begin
            oc          = mcb_pkg::OC_OVERFLOW;
            wr_status   = 1'b1;
            status_next = cur | over_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_count_reg  <= mcb_pkg::BANK_COUNT_RST;
            ctl_present_reg <= 1'b1;
            global_ctl_reg  <= 1'b1;
            uc_en_reg       <= mcb_pkg::UC_EN_RST;
            mce_en_reg      <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mcb_pkg::CFG_BANK_COUNT:
                    bank_count_reg <= cfg_data[mcb_pkg::BANK_NUM_W-1:0];
                mcb_pkg::CFG_CTL_PRESENT:
                    ctl_present_reg <= cfg_data[0];
                mcb_pkg::CFG_GLOBAL_CTL:
                    global_ctl_reg <= cfg_data[0];
                mcb_pkg::CFG_BANK_UC_EN:
                    uc_en_reg <= cfg_data[mcb_pkg::UC_EN_W-1:0];
                mcb_pkg::CFG_MCE_ENABLE:
                    mce_en_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= command;
            idx_reg  <= bank_index;
            st_reg   <= error_status;
            gsi_reg  <= global_status_in;
            addr_reg <= error_addr;
            misc_reg <= error_misc;
        end
        if (cmd.exec)
        begin
            outcome_reg  <= oc;
            bank_now_reg <= in_range ? status_next : '0;
            gs_now_reg   <= gs_next;
            irq_reg      <= (oc == mcb_pkg::OC_LOGGED_IRQ);
            rst_req_reg  <= (oc == mcb_pkg::OC_RESET);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_reg <= '0;
            for (int i = 0; i < NB; i++)
            begin
                status_mem_reg[i] <= '0;
                addr_mem_reg[i]   <= '0;
                misc_mem_reg[i]   <= '0;
            end
        end
        else if (cmd.exec)
        begin
            if (wr_gs)
            begin
                gs_reg <= gs_next;
            end
            if (wr_status)
            begin
                status_mem_reg[sel] <= status_next;
            end
            if (wr_log)
            begin
                addr_mem_reg[sel] <= addr_reg;
                misc_mem_reg[sel] <= misc_reg;
            end
        end
    end

    assign outcome           = outcome_reg;
    assign bank_status_now   = bank_now_reg;
    assign global_status_now = gs_now_reg;
    assign raise_interrupt   = irq_reg;
    assign request_reset     = rst_req_reg;

endmodule

// File: rtl/machine_check_bank_logger.sv
// Channel   Role    Payload
// inject    sink    command, bank_index, error_status, global_status_in,
//                   error_addr, error_misc
// result    source  outcome, bank_status_now, global_status_now,
//                   raise_interrupt, request_reset
// cfg       write   cfg_we, cfg_index, cfg_data
//
// Each item passes through accept, one read-modify-write of the bank
// register file, then the result register. The controller handles one
// item at a time, so a stalled result holds off the next item. Reset is
// asynchronous and clears all banks, the global status and the
// configuration to their defaults.
module machine_check_bank_logger (
    input  logic                           clk,
    input  logic                           rst_n,
    mcb_inject_if.sink                     inject,
    mcb_result_if.source                   result,
    input  logic                           cfg_we,
    input  logic [mcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcb_pkg::CFG_DATA_W-1:0] cfg_data
);

    mcb_pkg::ctrl_cmd_t cmd;

    mcb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (inject.valid),
        .in_ready  (inject.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    mcb_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .command           (inject.command),
        .bank_index        (inject.bank_index),
        .error_status      (inject.error_status),
        .global_status_in  (inject.global_status_in),
        .error_addr        (inject.error_addr),
        .error_misc        (inject.error_misc),
        .outcome           (result.outcome),
        .bank_status_now   (result.bank_status_now),
        .global_status_now (result.global_status_now),
        .raise_interrupt   (result.raise_interrupt),
        .request_reset     (result.request_reset)
    );

endmodule
